@@ rtl/dvt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvt_pkg
// Shared types and constants for the dynamic vector table.
// ----------------------------------------------------------------------------
package dvt_pkg;

    localparam int MAX_ENTRIES_DEF = 256;
    localparam int VALUE_W         = 32;
    localparam int IDX_W           = 8;
    localparam int CNT_W_DEF       = $clog2(MAX_ENTRIES_DEF + 1);
    localparam int CAP_W_DEF       = $clog2(MAX_ENTRIES_DEF) + 1;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_MEMBER = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD_WAIT,
        S_SCAN,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        status_t              status;
        logic [VALUE_W-1:0]   read_value;
        logic                 found;
    } result_t;

endpackage

@@ rtl/dvt_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvt_in_if / dvt_out_if
// Valid/ready channels carrying command words and result words.
// ----------------------------------------------------------------------------
interface dvt_in_if;

    logic                          valid;
    logic                          ready;
    dvt_pkg::cmd_t                 command;
    logic [dvt_pkg::VALUE_W-1:0]   value;
    logic [dvt_pkg::IDX_W-1:0]     index;

    modport source (output valid, output command, output value, output index, input ready);
    modport sink   (input valid, input command, input value, input index, output ready);

endinterface

interface dvt_out_if #(
    parameter int CNT_W = dvt_pkg::CNT_W_DEF,
    parameter int CAP_W = dvt_pkg::CAP_W_DEF
);

    logic                          valid;
    logic                          ready;
    dvt_pkg::status_t              status;
    logic [dvt_pkg::VALUE_W-1:0]   read_value;
    logic                          found;
    logic [CNT_W-1:0]              count;
    logic [CAP_W-1:0]              capacity;

    modport source (output valid, output status, output read_value, output found,
                    output count, output capacity, input ready);
    modport sink   (input valid, input status, input read_value, input found,
                    input count, input capacity, output ready);

endinterface

@@ rtl/dynamic_vector_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dynamic_vector_table
// Compacted value table with insert, remove-all, indexed read and
// membership commands, tracking a power-of-two capacity.
// ----------------------------------------------------------------------------
//  channel   dir  words
//  in_ch     in   command, value, index
//  out_ch    out  status, read_value, found, count, capacity
//
//  insert writes in S_IDLE, read waits in S_RD_WAIT, remove and membership
//  walk the table in S_SCAN (one RAM read per stored entry, compaction
//  writes overlap the walk); one command in flight; the output register
//  holds a result while the next command is accepted
//  reset: count 0, capacity 1; entry RAM is not cleared
// ----------------------------------------------------------------------------
module dynamic_vector_table #(
    parameter int MAX_ENTRIES = dvt_pkg::MAX_ENTRIES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    dvt_in_if.sink    in_ch,
    dvt_out_if.source out_ch
);

    import dvt_pkg::*;

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W = $clog2(MAX_ENTRIES) + 1;
    localparam int AW    = $clog2(MAX_ENTRIES);

    logic                res_valid;
    logic                res_ready;
    result_t             res;
    logic [CNT_W-1:0]    count;
    logic [CAP_W-1:0]    capacity;
    logic                ram_wr_en;
    logic [AW-1:0]       ram_wr_addr;
    logic [VALUE_W-1:0]  ram_wr_data;
    logic                ram_rd_en;
    logic [AW-1:0]       ram_rd_addr;
    logic [VALUE_W-1:0]  ram_rd_data;

    logic                out_valid_reg, out_valid_next;
    result_t             out_res_reg;
    logic [CNT_W-1:0]    out_count_reg;
    logic [CAP_W-1:0]    out_cap_reg;

    dvt_seq #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .CNT_W       (CNT_W),
        .CAP_W       (CAP_W),
        .AW          (AW)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_ch.valid),
        .in_ready    (in_ch.ready),
        .in_command  (in_ch.command),
        .in_value    (in_ch.value),
        .in_index    (in_ch.index),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .count       (count),
        .capacity    (capacity),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    dvt_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // output word register
    assign res_ready = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg   <= res;
            out_count_reg <= count;
            out_cap_reg   <= capacity;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.status     = out_res_reg.status;
    assign out_ch.read_value = out_res_reg.read_value;
    assign out_ch.found      = out_res_reg.found;
    assign out_ch.count      = out_count_reg;
    assign out_ch.capacity   = out_cap_reg;

endmodule

@@ rtl/dvt_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvt_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module dvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/dvt_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvt_seq
// Command sequencer: owns count and capacity, drives the entry RAM and
// walks it for membership and compacting remove.
// ----------------------------------------------------------------------------
module dvt_seq #(
    parameter int MAX_ENTRIES = dvt_pkg::MAX_ENTRIES_DEF,
    parameter int CNT_W       = $clog2(MAX_ENTRIES + 1),
    parameter int CAP_W       = $clog2(MAX_ENTRIES) + 1,
    parameter int AW          = $clog2(MAX_ENTRIES)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  dvt_pkg::cmd_t                  in_command,
    input  logic [dvt_pkg::VALUE_W-1:0]    in_value,
    input  logic [dvt_pkg::IDX_W-1:0]      in_index,
    output logic                           res_valid,
    input  logic                           res_ready,
    output dvt_pkg::result_t               res,
    output logic [CNT_W-1:0]               count,
    output logic [CAP_W-1:0]               capacity,
    output logic                           ram_wr_en,
    output logic [AW-1:0]                  ram_wr_addr,
    output logic [dvt_pkg::VALUE_W-1:0]    ram_wr_data,
    output logic                           ram_rd_en,
    output logic [AW-1:0]                  ram_rd_addr,
    input  logic [dvt_pkg::VALUE_W-1:0]    ram_rd_data
);

    import dvt_pkg::*;

    localparam int CMP_A = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int CMP_W = (CMP_A > IDX_W) ? CMP_A : IDX_W;

    seq_state_t          state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [VALUE_W-1:0]  val_reg, val_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CAP_W-1:0]    cap_reg, cap_next;
    logic [CNT_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic                pend_reg, pend_next;
    logic                hit_reg, hit_next;
    result_t             res_reg, res_next;

    logic                issue;
    logic                match;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cmd_reg    <= CMD_INSERT;
            count_reg  <= '0;
            cap_reg    <= CAP_W'(1);
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            pend_reg   <= 1'b0;
            hit_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cmd_reg    <= cmd_next;
            count_reg  <= count_next;
            cap_reg    <= cap_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            pend_reg   <= pend_next;
            hit_reg    <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        res_reg <= res_next;
    end

    assign issue = (rd_ptr_reg < count_reg);
    assign match = (ram_rd_data == val_reg);

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        val_next    = val_reg;
        count_next  = count_reg;
        cap_next    = cap_reg;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        pend_next   = pend_reg;
        hit_next    = hit_reg;
        res_next    = res_reg;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = count_reg[AW-1:0];
        ram_wr_data = in_value;
        ram_rd_en   = 1'b0;
        ram_rd_addr = AW'(in_index);

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_next = in_command;
                    val_next = in_value;
                    res_next = '{status: ST_OK, read_value: '0, found: 1'b0};
                    unique case (in_command)
                        CMD_INSERT:
                        begin
                            if (count_reg == CNT_W'(MAX_ENTRIES))
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                ram_wr_en  = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                if (CMP_W'(count_reg) == CMP_W'(cap_reg))
                                begin
                                    cap_next = cap_reg << 1;
                                end
                            end
                            state_next = S_DONE;
                        end
                        CMD_READ:
                        begin
                            if (CMP_W'(in_index) < CMP_W'(count_reg))
                            begin
                                ram_rd_en  = 1'b1;
                                state_next = S_RD_WAIT;
                            end
                            else
                            begin
                                res_next.status = ST_RANGE;
                                state_next      = S_DONE;
                            end
                        end
                        CMD_REMOVE, CMD_MEMBER:
                        begin
                            rd_ptr_next = '0;
                            wr_ptr_next = '0;
                            pend_next   = 1'b0;
                            hit_next    = 1'b0;
                            state_next  = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_RD_WAIT:
            begin
                res_next.read_value = ram_rd_data;
                state_next          = S_DONE;
            end

            S_SCAN:
            begin
                ram_rd_en   = issue;
                ram_rd_addr = rd_ptr_reg[AW-1:0];
                ram_wr_addr = wr_ptr_reg[AW-1:0];
                ram_wr_data = ram_rd_data;
                if (issue)
                begin
                    rd_ptr_next = rd_ptr_reg + CNT_W'(1);
                end
                pend_next = issue;
                if (pend_reg)
                begin
                    if (match)
                    begin
                        hit_next = 1'b1;
                    end
                    else if (cmd_reg == CMD_REMOVE)
                    begin
                        ram_wr_en   = 1'b1;
                        wr_ptr_next = wr_ptr_reg + CNT_W'(1);
                    end
                end
                if (!issue)
                begin
                    if (cmd_reg == CMD_REMOVE)
                    begin
                        count_next = wr_ptr_next;
                        if ((CMP_W'(wr_ptr_next) < CMP_W'(cap_reg >> 1)) &&
                            (cap_reg > CAP_W'(1)))
                        begin
                            cap_next = cap_reg >> 1;
                        end
                    end
                    else
                    begin
                        res_next.found = hit_next;
                    end
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res      = res_reg;
    assign count    = count_reg;
    assign capacity = cap_reg;

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above table size");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= CMP_W'(cap_reg))
        else $error("entry count above capacity");

    a_cap_pow2: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(cap_reg))
        else $error("capacity not a power of two");

    a_compact: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (wr_ptr_reg <= rd_ptr_reg))
        else $error("compaction write pointer passed read pointer");

    a_stable_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD_WAIT) |=> (state_reg == S_DONE) && $stable(count_reg))
        else $error("read disturbed table state");

endmodule

@@ verif/dynamic_vector_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dynamic_vector_table_tb
// Self-checking bench for the dynamic vector table. A class tracks the table
// contents, count and capacity from every accepted command word and checks
// each result word in order. The stimulus starts with a short directed run,
// then fills the table to full, drains it and mixes commands at random.
// Both channels idle at random.
// ----------------------------------------------------------------------------
module dynamic_vector_table_tb;

    import dvt_pkg::*;

    localparam int TABLE_DEPTH    = MAX_ENTRIES_DEF;
    localparam int CNT_W          = CNT_W_DEF;
    localparam int CAP_W          = CAP_W_DEF;
    localparam int ITEM_TARGET    = 1900;
    localparam int IDLE_PERCENT   = 12;
    localparam int CALM_FIRST     = 700;
    localparam int CALM_LAST      = 1000;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = TABLE_DEPTH + 40;
    localparam int MAX_REPORTS    = 30;

    typedef struct {
        status_t            status;
        logic [VALUE_W-1:0] read_value;
        logic               found;
        logic [CNT_W-1:0]   count;
        logic [CAP_W-1:0]   capacity;
    } table_result_t;

    class table_result_checker;
        logic [VALUE_W-1:0] stored [TABLE_DEPTH];
        int                 stored_count;
        int                 tracked_cap;
        table_result_t      pending_results [$];
        int                 errors;
        int                 results_seen;

        function new();
            stored_count = 0;
            tracked_cap  = 1;
            errors       = 0;
            results_seen = 0;
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= MAX_REPORTS)
            begin
                $display("[%0t] mismatch: %s", $realtime, what);
            end
        endtask

        function void note_command(cmd_t cmd, logic [VALUE_W-1:0] val,
                                   logic [IDX_W-1:0] idx);
            table_result_t exp_word;
            int            kept;
            exp_word.status     = ST_OK;
            exp_word.read_value = '0;
            exp_word.found      = 1'b0;
            case (cmd)
                CMD_INSERT:
                begin
                    if (stored_count >= TABLE_DEPTH)
                    begin
                        exp_word.status = ST_FULL;
                    end
                    else
                    begin
                        if (stored_count == tracked_cap)
                        begin
                            tracked_cap = tracked_cap * 2;
                        end
                        stored[stored_count] = val;
                        stored_count++;
                    end
                end
                CMD_REMOVE:
                begin
                    kept = 0;
                    for (int k = 0; k < stored_count; k++)
                    begin
                        if (stored[k] != val)
                        begin
                            stored[kept] = stored[k];
                            kept++;
                        end
                    end
                    stored_count = kept;
                    if (stored_count < tracked_cap / 2 && tracked_cap > 1)
                    begin
                        tracked_cap = tracked_cap / 2;
                    end
                end
                CMD_READ:
                begin
                    if (int'(idx) < stored_count)
                    begin
                        exp_word.read_value = stored[idx];
                    end
                    else
                    begin
                        exp_word.status = ST_RANGE;
                    end
                end
                default:
                begin
                    for (int k = 0; k < stored_count; k++)
                    begin
                        if (stored[k] == val)
                        begin
                            exp_word.found = 1'b1;
                        end
                    end
                end
            endcase
            exp_word.count    = CNT_W'(stored_count);
            exp_word.capacity = CAP_W'(tracked_cap);
            pending_results.push_back(exp_word);
        endfunction

        task check_result(status_t st, logic [VALUE_W-1:0] rv, logic fnd,
                          logic [CNT_W-1:0] cnt, logic [CAP_W-1:0] cap);
            table_result_t exp_word;
            if (pending_results.size() == 0)
            begin
                report_mismatch("result word with no command outstanding");
            end
            else
            begin
                exp_word = pending_results.pop_front();
                if (st !== exp_word.status)
                    report_mismatch($sformatf("word %0d status got %0d exp %0d",
                                              results_seen, st, exp_word.status));
                if (rv !== exp_word.read_value)
                    report_mismatch($sformatf("word %0d read_value got %h exp %h",
                                              results_seen, rv, exp_word.read_value));
                if (fnd !== exp_word.found)
                    report_mismatch($sformatf("word %0d found got %b exp %b",
                                              results_seen, fnd, exp_word.found));
                if (cnt !== exp_word.count)
                    report_mismatch($sformatf("word %0d count got %0d exp %0d",
                                              results_seen, cnt, exp_word.count));
                if (cap !== exp_word.capacity)
                    report_mismatch($sformatf("word %0d capacity got %0d exp %0d",
                                              results_seen, cap, exp_word.capacity));
            end
            results_seen++;
        endtask

        task flush_leftovers();
            if (pending_results.size() != 0)
            begin
                report_mismatch($sformatf("%0d result words never arrived",
                                          pending_results.size()));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    bit   calm;
    int   words_sent;
    int   quiet_cycles;

    table_result_checker sb = new();

    dvt_in_if  in_ch ();
    dvt_out_if out_ch ();

    dynamic_vector_table dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // result side back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // result checking and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                sb.check_result(out_ch.status, out_ch.read_value, out_ch.found,
                                out_ch.count, out_ch.capacity);
            end
            if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // entered and left at a rising edge
    task automatic send_word(cmd_t cmd, logic [VALUE_W-1:0] val, logic [IDX_W-1:0] idx);
        calm = (words_sent >= CALM_FIRST) && (words_sent < CALM_LAST);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.command <= cmd;
        in_ch.value   <= val;
        in_ch.index   <= idx;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        sb.note_command(cmd, val, idx);
        words_sent++;
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return VALUE_W'($urandom_range(0, 15));
        else if (r < 60 && sb.stored_count > 0)
            return sb.stored[$urandom_range(0, sb.stored_count - 1)];
        else
            return $urandom();
    endfunction

    function automatic logic [IDX_W-1:0] pick_index();
        int hi;
        hi = (sb.stored_count > 255) ? 255 : sb.stored_count;
        if ($urandom_range(0, 3) != 0)
            return IDX_W'($urandom_range(0, hi));
        else
            return IDX_W'($urandom_range(0, 255));
    endfunction

    task automatic send_random(int ins_pct, int rem_pct, int rd_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < ins_pct)
            send_word(CMD_INSERT, pick_value(), pick_index());
        else if (r < ins_pct + rem_pct)
            send_word(CMD_REMOVE, pick_value(), pick_index());
        else if (r < ins_pct + rem_pct + rd_pct)
            send_word(CMD_READ, $urandom(), pick_index());
        else
            send_word(CMD_MEMBER, pick_value(), pick_index());
    endtask

    task automatic run_directed();
        send_word(CMD_READ,   32'h0000_0000, 8'd0);
        send_word(CMD_MEMBER, 32'h0000_0007, 8'd0);
        send_word(CMD_REMOVE, 32'h0000_0007, 8'd0);
        send_word(CMD_INSERT, 32'h0000_0000, 8'd0);
        send_word(CMD_INSERT, 32'hFFFF_FFFF, 8'd255);
        send_word(CMD_INSERT, 32'h0000_0005, 8'd0);
        send_word(CMD_INSERT, 32'h0000_0005, 8'd0);
        send_word(CMD_INSERT, 32'h0000_0005, 8'd0);
        send_word(CMD_INSERT, 32'h0000_0000, 8'd0);
        send_word(CMD_READ,   32'h0000_0000, 8'd0);
        send_word(CMD_READ,   32'h0000_0000, 8'd1);
        send_word(CMD_READ,   32'h0000_0000, 8'd5);
        send_word(CMD_READ,   32'h0000_0000, 8'd6);
        send_word(CMD_READ,   32'hFFFF_FFFF, 8'd255);
        send_word(CMD_MEMBER, 32'hFFFF_FFFF, 8'd0);
        send_word(CMD_MEMBER, 32'h0000_0005, 8'd0);
        send_word(CMD_MEMBER, 32'h0000_0001, 8'd0);
        // adjacent duplicates go in one pass
        send_word(CMD_REMOVE, 32'h0000_0005, 8'd0);
        send_word(CMD_REMOVE, 32'h0000_0000, 8'd0);
        send_word(CMD_REMOVE, 32'h0000_0000, 8'd0);
        send_word(CMD_REMOVE, 32'hFFFF_FFFF, 8'd0);
        send_word(CMD_REMOVE, 32'h0000_0009, 8'd0);
        send_word(CMD_READ,   32'h0000_0000, 8'd0);
    endtask

    task automatic fill_to_full();
        while (sb.stored_count < TABLE_DEPTH)
        begin
            send_random(80, 4, 8);
        end
        repeat ($urandom_range(3, 6))
        begin
            send_word(CMD_INSERT, pick_value(), pick_index());
        end
        send_word(CMD_READ, $urandom(), 8'd255);
        send_word(CMD_READ, $urandom(), 8'd0);
    endtask

    task automatic drain_table();
        int budget;
        budget = 400;
        while (sb.stored_count > 0 && budget > 0)
        begin
            if ($urandom_range(0, 99) < 70)
                send_word(CMD_REMOVE, sb.stored[$urandom_range(0, sb.stored_count - 1)],
                          pick_index());
            else
                send_random(40, 0, 30);
            budget--;
        end
        repeat ($urandom_range(1, 4))
        begin
            send_word(CMD_REMOVE, pick_value(), pick_index());
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        calm          = 1'b0;
        words_sent    = 0;
        quiet_cycles  = 0;
        in_ch.valid   = 1'b0;
        in_ch.command = CMD_INSERT;
        in_ch.value   = '0;
        in_ch.index   = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        fill_to_full();
        drain_table();
        while (words_sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    if (words_sent < ITEM_TARGET - 350)
                        fill_to_full();
                    else
                        repeat (60) send_random(30, 20, 25);
                end
                1:
                begin
                    if (words_sent < ITEM_TARGET - 400)
                        drain_table();
                    else
                        repeat (60) send_random(30, 20, 25);
                end
                default:
                begin
                    repeat (60) send_random(30, 20, 25);
                end
            endcase
        end
        in_ch.valid <= 1'b0;

        while (sb.pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        sb.flush_leftovers();
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/dvt_pkg.sv
rtl/dvt_if.sv
rtl/dvt_ram.sv
rtl/dvt_seq.sv
rtl/dynamic_vector_table.sv
verif/dynamic_vector_table_tb.sv
